@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define PXTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define PXTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/pxtm_pkg.sv @@
// Types and constants for the pixel threshold / masked mean core.
// No dependencies.
package pxtm_pkg;

  localparam int PIX_W   = 8;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 32;
  localparam int MEAN_W  = 16;
  localparam int TDATA_W = 88;

  // Output tdata field offsets, lowest bit of each field
  localparam int OFS_MASK   = 0;
  localparam int OFS_COUNT  = 8;
  localparam int OFS_SUM    = 33;
  localparam int OFS_MEAN   = 65;
  localparam int OFS_MVALID = 81;
  localparam int OFS_STATUS = 82;
  localparam int OFS_PAD    = 83;

  localparam logic [PIX_W-1:0] MASK_ON  = 8'hff;
  localparam logic [PIX_W-1:0] MASK_OFF = 8'h00;

  localparam logic KIND_MASK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM
  } st_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] mean;
  } div_rsp_t;

endpackage

@@ rtl/core/pxtm_div.sv @@
// Radix-2 restoring divider for the masked mean: (sum << FRAC_BITS) / count,
// saturated to 16 bits. Depends on pxtm_pkg.
module pxtm_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pxtm_pkg::div_req_t req,
  output pxtm_pkg::div_rsp_t rsp
);

  localparam int QW  = pxtm_pkg::SUM_W + FRAC_BITS;
  localparam int CW  = $clog2(QW + 1);
  localparam int RW  = pxtm_pkg::CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] dsr_r, dsr_nxt;
  logic [RW:0]   shifted;
  logic          ge;

  always_comb begin
    shifted  = {rem_r, dvd_r[QW-1]};
    ge       = shifted >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = {req.sum, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dsr_nxt  = req.count;
    end else if (busy_r) begin
      // one quotient bit per cycle, shifted in from the bottom
      rem_nxt = ge ? RW'(shifted - {1'b0, dsr_r}) : shifted[RW-1:0];
      dvd_nxt = {dvd_r[QW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  // saturate any quotient wider than the mean field
  always_comb begin
    rsp.done = done_r;
    rsp.mean = (|dvd_r[QW-1:pxtm_pkg::MEAN_W]) ? {pxtm_pkg::MEAN_W{1'b1}}
                                               : dvd_r[pxtm_pkg::MEAN_W-1:0];
  end

endmodule

@@ rtl/core/pixel_threshold_masked_mean_core.sv @@
// Top level of the pixel threshold / masked mean core.
// Depends on pxtm_pkg and pxtm_div.
//
// Usage:
//   Pixels enter on the in_ stream, one 8-bit pixel per transaction, with
//   in_tlast on the final pixel of an image. Every pixel gives one mask
//   transaction on the out_ stream (out_tuser = 0, mask byte 0xff when the
//   pixel is strictly above the threshold, else 0x00). The final pixel also
//   gives a summary transaction (out_tuser = 1) carrying the marked count,
//   the marked sum, the mean in Q8 (truncated, saturated to 16 bits) and a
//   status bit; out_tlast marks the last transaction caused by a pixel.
//   The threshold is written through cfg_wr_en / cfg_wr_data while idle.
// Timing:
//   A mask result is registered in the output register as its pixel is
//   taken, and the next pixel can be taken while it is presented, so pixels
//   flow at one per cycle while the receiver takes them. After the last
//   pixel the restoring divider works out the quotient, and the summary is
//   loaded once the divider is done and the output register is free;
//   in_tready stays low until the summary is loaded.
//   A summary with a bad pixel count or no marked pixel skips the divider and
//   is loaded through the ST_SUM state once the mask transaction goes.
// Reset clears the threshold, the accumulators and the output valid flag.
// A stalled receiver holds the output register; in_tready drops until the
// waiting transaction is taken.
module pixel_threshold_masked_mean_core #(
  parameter int MAX_PIXELS     = 16777216,
  parameter int PIXEL_GROUP    = 64,
  parameter int MEAN_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [pxtm_pkg::PIX_W-1:0]   cfg_wr_data,   // threshold
  // pixel stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pxtm_pkg::PIX_W-1:0]   in_tdata,      // [7:0] pixel
  input  logic                         in_tlast,      // last_pixel
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [7:0] mask_value, [32:8] masked_count, [64:33] masked_sum,
  // [80:65] mean_q8, [81] mean_valid, [82] status, [87:83] zero
  output logic [pxtm_pkg::TDATA_W-1:0] out_tdata,
  output logic                         out_tuser,     // [0] kind
  output logic                         out_tlast      // last_result
);

  localparam int CNT_W = pxtm_pkg::CNT_W;
  localparam int SUM_W = pxtm_pkg::SUM_W;
  localparam int GW    = (PIXEL_GROUP > 1) ? $clog2(PIXEL_GROUP) : 1;

  // threshold register
  logic [pxtm_pkg::PIX_W-1:0] thr_r;

  // accumulators
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [GW-1:0]    grp_r, grp_nxt;
  logic             ovf_r, ovf_nxt;

  // captured summary
  logic [SUM_W-1:0] qsum_r, qsum_nxt;
  logic [CNT_W-1:0] qcnt_r, qcnt_nxt;
  logic             qbad_r, qbad_nxt;

  // output register
  logic                         ovalid_r, ovalid_nxt;
  logic [pxtm_pkg::TDATA_W-1:0] odata_r, odata_nxt;
  logic                         okind_r, okind_nxt;
  logic                         olast_r, olast_nxt;

  pxtm_pkg::st_t     st_r, st_nxt;
  pxtm_pkg::div_req_t div_req;
  pxtm_pkg::div_rsp_t div_rsp;

  logic in_acc, out_free, marked, skip_div, load_sum, bad;

  assign out_free = !ovalid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;
  assign marked   = in_tdata > thr_r;

  // accumulate the pixel; past the limit only flag the overflow
  always_comb begin
    sum_nxt  = sum_r;
    mcnt_nxt = mcnt_r;
    pcnt_nxt = pcnt_r;
    grp_nxt  = grp_r;
    ovf_nxt  = ovf_r;
    if (in_acc) begin
      if (pcnt_r >= CNT_W'(MAX_PIXELS)) begin
        ovf_nxt = 1'b1;
      end else begin
        pcnt_nxt = pcnt_r + CNT_W'(1);
        grp_nxt  = (grp_r == GW'(PIXEL_GROUP - 1)) ? '0 : grp_r + GW'(1);
        if (marked) begin
          mcnt_nxt = mcnt_r + CNT_W'(1);
          sum_nxt  = sum_r + SUM_W'(in_tdata);
        end
      end
    end
    bad      = ovf_nxt || (pcnt_nxt == '0) || (grp_nxt != '0);
    qsum_nxt = qsum_r;
    qcnt_nxt = qcnt_r;
    qbad_nxt = qbad_r;
    if (in_acc && in_tlast) begin
      // capture the image totals, then clear for the next image
      qsum_nxt = sum_nxt;
      qcnt_nxt = mcnt_nxt;
      qbad_nxt = bad;
      sum_nxt  = '0;
      mcnt_nxt = '0;
      pcnt_nxt = '0;
      grp_nxt  = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // judge on the captured count, the running one is already cleared
  assign skip_div = bad || (qcnt_nxt == '0);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pxtm_pkg::ST_IDLE: begin
        if (in_acc && in_tlast) begin
          st_nxt = skip_div ? pxtm_pkg::ST_SUM : pxtm_pkg::ST_DIV;
        end
      end
      pxtm_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          st_nxt = pxtm_pkg::ST_SUM;
        end
      end
      pxtm_pkg::ST_SUM: begin
        if (out_free) begin
          st_nxt = pxtm_pkg::ST_IDLE;
        end
      end
      default: st_nxt = pxtm_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready     = 1'b0;
    load_sum      = 1'b0;
    div_req.start = 1'b0;
    div_req.sum   = sum_nxt;
    div_req.count = mcnt_nxt;
    case (st_r)
      pxtm_pkg::ST_IDLE: begin
        in_tready = out_free;
        // operands are taken before the accumulators clear
        div_req.sum   = (in_acc && in_tlast) ? qsum_nxt : sum_nxt;
        div_req.count = (in_acc && in_tlast) ? qcnt_nxt : mcnt_nxt;
        div_req.start = in_acc && in_tlast && !skip_div;
      end
      pxtm_pkg::ST_SUM: load_sum = out_free;
      default: ;
    endcase
  end

  // output register: mask on pixel, summary in ST_SUM, after the divider or when it is skipped
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    if (in_acc) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = '0;
      odata_nxt[pxtm_pkg::OFS_MASK +: pxtm_pkg::PIX_W] =
        marked ? pxtm_pkg::MASK_ON : pxtm_pkg::MASK_OFF;
      okind_nxt  = pxtm_pkg::KIND_MASK;
      olast_nxt  = !in_tlast;
    end else if (load_sum) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = '0;
      okind_nxt  = pxtm_pkg::KIND_SUMMARY;
      olast_nxt  = 1'b1;
      if (qbad_r) begin
        odata_nxt[pxtm_pkg::OFS_STATUS] = 1'b1;
      end else begin
        odata_nxt[pxtm_pkg::OFS_COUNT +: CNT_W] = qcnt_r;
        odata_nxt[pxtm_pkg::OFS_SUM +: SUM_W]   = qsum_r;
        if (qcnt_r != '0) begin
          odata_nxt[pxtm_pkg::OFS_MEAN +: pxtm_pkg::MEAN_W] = div_rsp.mean;
          odata_nxt[pxtm_pkg::OFS_MVALID] = 1'b1;
        end
      end
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      sum_r    <= '0;
      mcnt_r   <= '0;
      pcnt_r   <= '0;
      grp_r    <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
      st_r     <= pxtm_pkg::ST_IDLE;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      sum_r    <= sum_nxt;
      mcnt_r   <= mcnt_nxt;
      pcnt_r   <= pcnt_nxt;
      grp_r    <= grp_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
      st_r     <= st_nxt;
    end
    qsum_r  <= qsum_nxt;
    qcnt_r  <= qcnt_nxt;
    qbad_r  <= qbad_nxt;
    odata_r <= odata_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

  pxtm_div #(
    .FRAC_BITS (MEAN_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule

@@ rtl/core/pxtm_chk.sv @@
// Port-level checker for the pixel threshold / masked mean core, with bind.
// Depends on pxtm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pxtm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         in_tlast,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [pxtm_pkg::TDATA_W-1:0] out_tdata,
  input logic                         out_tuser,
  input logic                         out_tlast
);

  // output register is empty after reset
  `PXTM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // a stalled transaction holds
  `PXTM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // summary always closes the results of a pixel
  `PXTM_ASSERT(a_sum_last, out_tvalid && out_tuser |-> out_tlast, "summary without tlast")

  // the block stops taking pixels right after the last one of an image
  `PXTM_ASSERT(a_last_stall, in_tvalid && in_tready && in_tlast |=> !in_tready, "pixel taken during summary")

  // a bad count reports nothing but the status bit
  `PXTM_ASSERT(a_bad_zero, out_tvalid && out_tuser && out_tdata[pxtm_pkg::OFS_STATUS] |-> out_tdata[pxtm_pkg::OFS_STATUS-1:0] == '0, "bad summary carries data")

endmodule

bind pixel_threshold_masked_mean_core pxtm_chk u_pxtm_chk (.*);

@@ sim/tb_pixel_threshold_masked_mean_core.sv @@
// Testbench for pixel_threshold_masked_mean_core: a directed table, then random images.
// Every transaction is checked against the table's given values or an in-bench model of the threshold and running mean.
// Depends on pxtm_pkg and the core RTL only.
module tb_pixel_threshold_masked_mean_core;
  import pxtm_pkg::*;

  // Lower the pixel ceiling so that the overflow path is reached within a short run.
  // The grouping and the fraction width stay at their defaults.
  localparam int MAX_PIX = 256;
  localparam int GROUP   = 64;
  localparam int FRAC    = 8;

  localparam int HOLDOFF_CYCLES = 300;
  localparam int IDLE_PERCENT   = 28;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_COUNT = 1'b1;

  // One transaction on the result stream, already split into its fields.
  typedef struct packed {
    logic              kind;
    logic [PIX_W-1:0]  mask;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [MEAN_W-1:0] mean;
    logic              mvalid;
    logic              status;
    logic              last;
  } pxout_t;

  // One row of the directed table. Where typed is set, the mask and the summary
  // status are given here; the other rows go through the model.
  typedef struct packed {
    logic             wr_cfg;
    logic [PIX_W-1:0] thr;
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             typed;
    logic [PIX_W-1:0] mask_exp;
    logic             status_exp;
  } dir_row_t;

  typedef enum logic [1:0] {
    FILL_DARK,
    FILL_BRIGHT,
    FILL_EDGE,
    FILL_NOISE
  } fill_t;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [PIX_W-1:0]    cfg_wr_data = '0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [PIX_W-1:0]    in_tdata    = '0;
  logic                in_tlast    = 1'b0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  // Model state: the threshold as last written, and the running tallies.
  logic [PIX_W-1:0]    thr_shadow = '0;
  logic [SUM_W-1:0]    sum_tally;
  logic [CNT_W-1:0]    marked_tally;
  logic [CNT_W-1:0]    pixel_tally;
  logic                tally_overflow;

  pxout_t              mask_summary_q[$];
  int                  mismatch_count  = 0;
  int                  pixels_sent     = 0;
  logic                idling_enabled  = 1'b1;
  logic                holdoff_request = 1'b0;

  pixel_threshold_masked_mean_core #(
    .MAX_PIXELS     (MAX_PIX),
    .PIXEL_GROUP    (GROUP),
    .MEAN_FRAC_BITS (FRAC)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic idle_now();
    return idling_enabled && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(fill_t fill);
    int v;
    case (fill)
      FILL_DARK:   return 8'h00;
      FILL_BRIGHT: return 8'hff;
      FILL_EDGE: begin
        // Stay within two steps of the threshold to probe the strict comparison.
        v = int'(thr_shadow) + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
      default:     return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Work out the mask transaction for one pixel and, on the last pixel of an
  // image, the summary transaction; advance the tallies as the core does.
  task automatic mask_and_tally(input logic [PIX_W-1:0] pix, input logic last,
                                output pxout_t mres, output pxout_t sres);
    logic        marked;
    logic        bad;
    logic [63:0] quot;
    marked = pix > thr_shadow;
    if (pixel_tally >= CNT_W'(MAX_PIX)) begin
      tally_overflow = 1'b1;
    end else begin
      pixel_tally++;
      if (marked) begin
        marked_tally++;
        sum_tally += SUM_W'(pix);
      end
    end
    mres      = '0;
    mres.kind = KIND_MASK;
    mres.mask = marked ? MASK_ON : MASK_OFF;
    mres.last = !last;
    sres      = '0;
    if (last) begin
      sres.kind = KIND_SUMMARY;
      sres.mask = MASK_OFF;
      sres.last = 1'b1;
      bad = tally_overflow || (pixel_tally == '0) || (pixel_tally % CNT_W'(GROUP) != '0);
      if (bad) begin
        sres.status = STATUS_BAD_COUNT;
      end else begin
        sres.status = STATUS_OK;
        sres.count  = marked_tally;
        sres.sum    = sum_tally;
        if (marked_tally != '0) begin
          quot        = (64'(sum_tally) << FRAC) / 64'(marked_tally);
          sres.mean   = (quot > 64'hffff) ? 16'hffff : quot[MEAN_W-1:0];
          sres.mvalid = 1'b1;
        end
      end
      sum_tally      = '0;
      marked_tally   = '0;
      pixel_tally    = '0;
      tally_overflow = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch on %s at %0t: got 0x%0h, want 0x%0h", what, $time, got, want);
    mismatch_count++;
  endtask

  // Offer one pixel; return at the rising edge that takes the transaction.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    @(negedge clk);
    while (idle_now()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = pix;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // Drop valid and hold until every owed transaction has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (mask_summary_q.size() != 0) @(negedge clk);
  endtask

  // Write the threshold only with the core idle.
  task automatic write_threshold(input logic [PIX_W-1:0] value);
    drain();
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    thr_shadow  = value;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        out_tready      = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_tready = !idle_now();
    end
  end

  // Checker: compare each result transaction with the oldest one owed.
  always @(posedge clk) begin
    pxout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (mask_summary_q.size() == 0) begin
        flag_mismatch("transaction with nothing owed", out_tuser, 0);
      end else begin
        want = mask_summary_q.pop_front();
        if (out_tuser !== want.kind)
          flag_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[OFS_MASK +: PIX_W] !== want.mask)
          flag_mismatch("mask_value", out_tdata[OFS_MASK +: PIX_W], want.mask);
        if (out_tdata[OFS_COUNT +: CNT_W] !== want.count)
          flag_mismatch("masked_count", out_tdata[OFS_COUNT +: CNT_W], want.count);
        if (out_tdata[OFS_SUM +: SUM_W] !== want.sum)
          flag_mismatch("masked_sum", out_tdata[OFS_SUM +: SUM_W], want.sum);
        if (out_tdata[OFS_MEAN +: MEAN_W] !== want.mean)
          flag_mismatch("mean_q8", out_tdata[OFS_MEAN +: MEAN_W], want.mean);
        if (out_tdata[OFS_MVALID] !== want.mvalid)
          flag_mismatch("mean_valid", out_tdata[OFS_MVALID], want.mvalid);
        if (out_tdata[OFS_STATUS] !== want.status)
          flag_mismatch("status", out_tdata[OFS_STATUS], want.status);
        if (out_tdata[TDATA_W-1:OFS_PAD] !== '0)
          flag_mismatch("padding", out_tdata[TDATA_W-1:OFS_PAD], 0);
        if (out_tlast !== want.last)
          flag_mismatch("last_result", out_tlast, want.last);
      end
    end
  end

  // Stimulus: reset, directed table, random images, then wind down.
  initial begin
    dir_row_t         directed_rows [15];
    dir_row_t         row;
    pxout_t           mres;
    pxout_t           sres;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] new_thr;
    logic             last;
    fill_t            fill;
    int               img;
    int               img_len;
    int               pick;

    sum_tally      = '0;
    marked_tally   = '0;
    pixel_tally    = '0;
    tally_overflow = 1'b0;

    // wr_cfg, thr, pix, last, typed, mask_exp, status_exp
    directed_rows = '{
      // threshold at its reset value: zero stays dark, one and full scale mark
      '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1, MASK_OFF, STATUS_OK},
      '{1'b0, 8'h00, 8'h01, 1'b0, 1'b1, MASK_ON,  STATUS_OK},
      '{1'b0, 8'h00, 8'hff, 1'b0, 1'b1, MASK_ON,  STATUS_OK},
      // four-pixel image: count not a whole group
      '{1'b0, 8'h00, 8'h80, 1'b1, 1'b1, MASK_ON,  STATUS_BAD_COUNT},
      // top threshold marks nothing; one-pixel image
      '{1'b1, 8'hff, 8'hff, 1'b1, 1'b1, MASK_OFF, STATUS_BAD_COUNT},
      // mid threshold: equal is dark, one above marks
      '{1'b1, 8'h7f, 8'h7f, 1'b0, 1'b1, MASK_OFF, STATUS_OK},
      '{1'b0, 8'h7f, 8'h80, 1'b0, 1'b1, MASK_ON,  STATUS_OK},
      '{1'b0, 8'h7f, 8'haa, 1'b0, 1'b0, MASK_OFF, STATUS_OK},
      '{1'b0, 8'h7f, 8'h55, 1'b0, 1'b0, MASK_OFF, STATUS_OK},
      '{1'b0, 8'h7f, 8'h00, 1'b1, 1'b0, MASK_OFF, STATUS_OK},
      // back to zero, single bright pixel
      '{1'b1, 8'h00, 8'hff, 1'b1, 1'b1, MASK_ON,  STATUS_BAD_COUNT},
      // threshold 0xa5: each nibble alternates its bits
      '{1'b1, 8'ha5, 8'ha5, 1'b0, 1'b1, MASK_OFF, STATUS_OK},
      '{1'b0, 8'ha5, 8'ha6, 1'b0, 1'b1, MASK_ON,  STATUS_OK},
      '{1'b0, 8'ha5, 8'h5a, 1'b0, 1'b0, MASK_OFF, STATUS_OK},
      '{1'b0, 8'ha5, 8'hfe, 1'b1, 1'b0, MASK_OFF, STATUS_OK}
    };

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.wr_cfg) write_threshold(row.thr);
      send_pixel(row.pix, row.last);
      mask_and_tally(row.pix, row.last, mres, sres);
      if (row.typed) begin
        mres      = '0;
        mres.kind = KIND_MASK;
        mres.mask = row.mask_exp;
        mres.last = !row.last;
        if (row.last) begin
          sres        = '0;
          sres.kind   = KIND_SUMMARY;
          sres.status = row.status_exp;
          sres.last   = 1'b1;
        end
      end
      mask_summary_q.push_back(mres);
      if (row.last) mask_summary_q.push_back(sres);
    end

    // Random images: mostly whole groups, some over the ceiling, the rest broken.
    img = 0;
    while (pixels_sent < 1300) begin
      if (img % 3 == 0) begin
        case ($urandom_range(3))
          0:       new_thr = 8'h00;
          1:       new_thr = 8'hff;
          default: new_thr = PIX_W'($urandom_range(255));
        endcase
        write_threshold(new_thr);
      end
      // Stall the receiver for a long stretch while pixels keep coming.
      if (img == 3) holdoff_request = 1'b1;
      // Run a stretch of images with both sides flat out.
      idling_enabled = !(img >= 10 && img < 16);

      pick = $urandom_range(99);
      if (pick < 45)
        img_len = GROUP;
      else if (pick < 55)
        img_len = GROUP * $urandom_range(2, MAX_PIX / GROUP);
      else if (pick < 60)
        img_len = MAX_PIX + $urandom_range(1, 40);
      else if (pick < 88)
        img_len = $urandom_range(1, 40);
      else
        img_len = $urandom_range(GROUP + 1, 2 * GROUP - 1);
      fill = fill_t'($urandom_range(3));

      for (int k = 0; k < img_len; k++) begin
        pix  = pick_pixel(fill);
        last = (k == img_len - 1);
        send_pixel(pix, last);
        mask_and_tally(pix, last, mres, sres);
        mask_summary_q.push_back(mres);
        if (last) mask_summary_q.push_back(sres);
      end
      img++;
    end

    // Wait out what is owed, then give the divider time to show any stray transaction.
    drain();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pxtm_pkg.sv
rtl/core/pxtm_div.sv
rtl/core/pixel_threshold_masked_mean_core.sv
rtl/core/pxtm_chk.sv
sim/tb_pixel_threshold_masked_mean_core.sv
